// ===== rtl/core/spv_pkg.sv =====
package spv_pkg;

    localparam int PacketBytesDefault = 26;
    localparam int CaptureLimit       = 26;
    localparam logic [7:0] CountMax   = 8'hFF;

    // register indexes on the configuration channel
    localparam logic [1:0] RegVersion = 2'd0;
    localparam logic [1:0] RegIdMin   = 2'd1;
    localparam logic [1:0] RegIdMax   = 2'd2;

    // verdict codes
    localparam logic [2:0] VerdictOk      = 3'd0;
    localparam logic [2:0] VerdictLength  = 3'd1;
    localparam logic [2:0] VerdictVersion = 3'd2;
    localparam logic [2:0] VerdictDevice  = 3'd3;
    localparam logic [2:0] VerdictRange   = 3'd4;

    // float bounds as IEEE single bits
    localparam logic [31:0] FltNeg60  = 32'hC270_0000;
    localparam logic [31:0] Flt150    = 32'h4316_0000;
    localparam logic [31:0] Flt100    = 32'h42C8_0000;
    localparam logic [31:0] Flt1000   = 32'h447A_0000;
    localparam logic [31:0] Flt5000   = 32'h459C_4000;

    // assembled packet handed from the front part to the back part
    typedef struct packed {
        logic        len_ok;
        logic [7:0]  version;
        logic [31:0] id;
        logic [31:0] seq;
        logic [31:0] f0;
        logic [31:0] f1;
        logic [31:0] f2;
        logic [31:0] f3;
        logic [7:0]  status;
    } pkt_t;

    // result word
    typedef struct packed {
        logic [7:0]  status;
        logic [31:0] voc;
        logic [31:0] pm;
        logic [31:0] hum;
        logic [31:0] temp;
        logic [31:0] seq;
        logic [31:0] id;
        logic [2:0]  verdict;
        logic        accepted;
    } res_t;

    // finite and lo <= v <= hi, for lo <= 0 < hi; -0 treated as 0
    function automatic logic in_range(input logic [31:0] v, input logic [31:0] lo,
                                      input logic [31:0] hi);
        logic fin;
        logic zero;
        logic lo_ok;
        logic hi_ok;
        fin  = (v[30:23] != 8'hFF);
        zero = (v[30:0] == 31'd0);
        if (v[31])
            lo_ok = zero || (lo[31] && (v[30:0] <= lo[30:0]));
        else
            lo_ok = 1'b1;
        hi_ok = v[31] || (v[30:0] <= hi[30:0]);
        return fin && lo_ok && hi_ok;
    endfunction

endpackage

// ===== rtl/core/sensor_packet_validator.sv =====
// Sensor packet validator.
// s_axis: one packet byte per word, tdata = data_byte, tlast = end_of_packet.
// m_axis: one verdict word per packet, no tlast; tdata fields listed
//   at the port. Rejected packets return zero in all fields after verdict.
// cfg: write channel, cfg_index 0 expected version, 1 id minimum, 2 id maximum;
//   other indexes are ignored. Write only while idle.
// Throughput: one byte per cycle while s_axis_tready is high. The front
//   part captures each byte by position; finished packets go to a
//   two-entry queue; the back part grades them and registers the result.
// The verdict for a packet is offered once it has passed the queue and has
//   been graded into the output register, which is loaded when it is free.
// Reset clears the byte counter, queue fill and output valid flag; registers
//   return to version 1, id bounds 0 and 0xFFFFFFFF.
// When m_axis stalls, the result is held, the queue fills and s_axis_tready
//   drops only once two finished packets wait behind it.
module sensor_packet_validator #(
    parameter int PACKET_BYTES = spv_pkg::PacketBytesDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tlast,   // end_of_packet
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // accepted, verdict[3], sender_id, sequence_number, temperature_bits,
    // humidity_bits, particulate_bits, voc_bits, status_byte, zero fill
    output logic [207:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic          q_valid;
    logic          q_ready;
    spv_pkg::pkt_t q_pkt;
    spv_pkg::res_t res;
    logic [7:0]    exp_version_reg;
    logic [31:0]   id_min_reg;
    logic [31:0]   id_max_reg;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_version_reg <= 8'd1;
            id_min_reg      <= 32'd0;
            id_max_reg      <= 32'hFFFF_FFFF;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                spv_pkg::RegVersion: exp_version_reg <= cfg_data[7:0];
                spv_pkg::RegIdMin:   id_min_reg      <= cfg_data;
                spv_pkg::RegIdMax:   id_max_reg      <= cfg_data;
                default:             ;
            endcase
        end
    end

    spv_front #(.PACKET_BYTES(PACKET_BYTES)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_pkt    (q_pkt)
    );

    spv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_pkt       (q_pkt),
        .exp_version (exp_version_reg),
        .id_min      (id_min_reg),
        .id_max      (id_max_reg),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res         (res)
    );

    assign m_axis_tdata = {4'd0, res};

endmodule

// ===== rtl/core/spv_front.sv =====
module spv_front #(
    parameter int PACKET_BYTES = spv_pkg::PacketBytesDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output logic          q_valid,
    input  logic          q_ready,
    output spv_pkg::pkt_t q_pkt
);

    logic [7:0]    count_reg;
    spv_pkg::pkt_t acc_reg;
    spv_pkg::pkt_t acc_next;
    logic          fire;
    logic [7:0]    pos;
    logic [1:0]    byte_sel;

    // skid queue of two entries
    spv_pkg::pkt_t buf_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    fill_reg;
    logic          push;
    logic          pop;

    assign in_ready = (fill_reg != 2'd2);
    assign fire     = in_valid && in_ready;
    assign pos      = count_reg;
    assign push     = fire && in_last;
    assign pop      = q_valid && q_ready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_pkt    = buf_reg[rd_ptr_reg];

    // byte lane inside a 32-bit field, wrapping modulo four
    assign byte_sel = pos[1:0] - 2'd1;

    // capture the byte by its position
    always_comb
    begin
        acc_next = acc_reg;
        if (pos == 8'd0)
            acc_next.version = in_byte;
        else if (pos <= 8'd4)
            acc_next.id[8*byte_sel +: 8] = in_byte;
        else if (pos <= 8'd8)
            acc_next.seq[8*byte_sel +: 8] = in_byte;
        else if (pos <= 8'd12)
            acc_next.f0[8*byte_sel +: 8] = in_byte;
        else if (pos <= 8'd16)
            acc_next.f1[8*byte_sel +: 8] = in_byte;
        else if (pos <= 8'd20)
            acc_next.f2[8*byte_sel +: 8] = in_byte;
        else if (pos <= 8'd24)
            acc_next.f3[8*byte_sel +: 8] = in_byte;
        else if (pos == 8'(spv_pkg::CaptureLimit - 1))
            acc_next.status = in_byte;
        acc_next.len_ok = (pos == 8'(PACKET_BYTES - 1));
    end

    // advance byte counter and packet register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            acc_reg   <= '0;
        end
        else if (fire)
        begin
            if (in_last)
            begin
                count_reg <= '0;
                acc_reg   <= '0;
            end
            else
            begin
                acc_reg <= acc_next;
                if (count_reg != spv_pkg::CountMax)
                    count_reg <= count_reg + 8'd1;
            end
        end
    end

    // hold finished packets for the back part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= acc_next;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> count_reg == 8'd0) else $error("count not cleared");
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3) else $error("bad fill");

endmodule

// ===== rtl/core/spv_back.sv =====
module spv_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  spv_pkg::pkt_t q_pkt,
    input  logic [7:0]    exp_version,
    input  logic [31:0]   id_min,
    input  logic [31:0]   id_max,
    output logic          res_valid,
    input  logic          res_ready,
    output spv_pkg::res_t res
);

    logic [2:0]    verdict;
    spv_pkg::res_t res_next;
    spv_pkg::res_t res_reg;
    logic          valid_reg;

    assign q_ready   = !valid_reg || res_ready;
    assign res_valid = valid_reg;
    assign res       = res_reg;

    // grade the packet in priority order
    always_comb
    begin
        if (!q_pkt.len_ok)
            verdict = spv_pkg::VerdictLength;
        else if (q_pkt.version != exp_version)
            verdict = spv_pkg::VerdictVersion;
        else if (q_pkt.id < id_min || q_pkt.id > id_max)
            verdict = spv_pkg::VerdictDevice;
        else if (!spv_pkg::in_range(q_pkt.f0, spv_pkg::FltNeg60, spv_pkg::Flt150) ||
                 !spv_pkg::in_range(q_pkt.f1, 32'd0, spv_pkg::Flt100) ||
                 !spv_pkg::in_range(q_pkt.f2, 32'd0, spv_pkg::Flt1000) ||
                 !spv_pkg::in_range(q_pkt.f3, 32'd0, spv_pkg::Flt5000))
            verdict = spv_pkg::VerdictRange;
        else
            verdict = spv_pkg::VerdictOk;
        res_next = '0;
        res_next.verdict = verdict;
        if (verdict == spv_pkg::VerdictOk)
        begin
            res_next.accepted = 1'b1;
            res_next.id       = q_pkt.id;
            res_next.seq      = q_pkt.seq;
            res_next.temp     = q_pkt.f0;
            res_next.hum      = q_pkt.f1;
            res_next.pm       = q_pkt.f2;
            res_next.voc      = q_pkt.f3;
            res_next.status   = q_pkt.status;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_ready)
            valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_ready && q_valid)
            res_reg <= res_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !res_ready |=> valid_reg && $stable(res_reg)) else $error("lost result");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !res_reg.accepted |-> res_reg.id == 32'd0) else $error("id leak");
    a_acc: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> res_reg.accepted == (res_reg.verdict == spv_pkg::VerdictOk))
        else $error("accepted mismatch");

endmodule
